// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by arp_cache_lru_timeout.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== hdl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants of the ARP binding cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned ARPC_ENTRIES = 16;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned HALF_W  = 16;

  localparam logic [HALF_W-1:0] MIN_FRAME_LEN  = 16'd42;
  localparam logic [HALF_W-1:0] ARP_ETHER_TYPE = 16'h0806;
  localparam logic [HALF_W-1:0] HTYPE_ETH      = 16'h0001;
  localparam logic [HALF_W-1:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [HALF_W-1:0] TIMEOUT_RESET  = 16'd300;

  typedef enum logic [1:0] {
    CMD_LEARN  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LEARNED  = 3'd0,
    ST_REJECTED = 3'd1,
    ST_HIT      = 3'd2,
    ST_MISS     = 3'd3,
    ST_TICKED   = 3'd4
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               capture;
    logic [IP_W-1:0]    ip;
    logic [STAMP_W-1:0] now;
    logic [HALF_W-1:0]  timeout;
  } cell_cmd_t;

endpackage

// ===== hdl/arp_cache_lru_timeout.sv =====
// A cache of IPv4-to-MAC bindings kept as a chain of ENTRIES cells in recency
// order, most recent first. An item is accepted only while no other is in
// flight: in the accept cycle every cell compares the queried IP and checks its
// age in parallel, and once the output register is free or being read, the
// chain shifts by one position up to the hit (or through the whole chain for a
// new binding) and the result beat is loaded into the output register. The
// item stage holds for as long as the output register is full and not taken.
// Reset empties the table at once; there is no clearing pass. The timeout
// register may be written at any time the block is idle and is always ready.
// ----------------------------------------------------------------------------
// arp_cache_lru_timeout
// ARP binding cache with LRU replacement and entry aging.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_cache_lru_timeout
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ARPC_ENTRIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,    // timeout_seconds
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // ip_addr, mac_addr, frame_len, ether_type,
                                      // hw_type, proto_type
  input  logic [1:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // mac_result
  output logic [2:0]   m_axis_tuser   // status
);

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_BUSY = 2'b10
  } fsm_e;

  fsm_e               state_q, state_d;
  cmd_e               cmd_q;
  logic [IP_W-1:0]    ip_q;
  logic [MAC_W-1:0]   mac_q;
  logic               frame_ok_q;
  logic [STAMP_W-1:0] now_q;
  logic [HALF_W-1:0]  timeout_q;
  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic [MAC_W-1:0]   out_mac_q;

  logic               in_fire;
  logic               commit;
  logic               frame_ok;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] fresh;
  logic [ENTRIES-1:0] shift;
  logic               any_match;
  logic               hit;
  logic               learn_ok;
  logic               update;
  logic [MAC_W-1:0]   sel_mac;
  logic [STAMP_W-1:0] sel_stamp;
  entry_t             front;
  entry_t             entries [ENTRIES];
  cell_cmd_t          cell_cmd;
  status_e            status;
  logic [MAC_W-1:0]   mac_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == FSM_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == FSM_BUSY) && (!out_valid_q || m_axis_tready);

  assign frame_ok = (s_axis_tdata[95:80] >= MIN_FRAME_LEN) &&
                    (s_axis_tdata[111:96] == ARP_ETHER_TYPE) &&
                    (s_axis_tdata[127:112] == HTYPE_ETH) &&
                    (s_axis_tdata[143:128] == PTYPE_IPV4);

  assign cell_cmd = '{capture: in_fire, ip: s_axis_tdata[31:0], now: now_q,
                      timeout: timeout_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (in_fire) state_d = FSM_BUSY;
      FSM_BUSY: if (commit) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // one-hot select of the matching cell
  always_comb begin
    sel_mac   = '0;
    sel_stamp = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (match[k]) begin
        sel_mac   = sel_mac | entries[k].mac;
        sel_stamp = sel_stamp | entries[k].stamp;
      end
    end
  end

  assign any_match = |match;
  assign hit       = |(match & fresh);
  assign learn_ok  = (cmd_q == CMD_LEARN) && frame_ok_q;
  assign update    = commit && (learn_ok || ((cmd_q == CMD_LOOKUP) && hit));

  // shift every cell up to and including the hit, or the whole chain on insert
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      shift[k] = update && ((k == 0) || (learn_ok && !any_match) || (|(match >> k)));
    end
  end

  assign front = '{valid: 1'b1,
                   ip:    ip_q,
                   mac:   learn_ok ? mac_q : sel_mac,
                   stamp: learn_ok ? now_q : sel_stamp};

  always_comb begin
    status  = ST_REJECTED;
    mac_res = '0;
    case (cmd_q)
      CMD_LEARN:  status = frame_ok_q ? ST_LEARNED : ST_REJECTED;
      CMD_LOOKUP: begin
        status  = hit ? ST_HIT : ST_MISS;
        mac_res = hit ? sel_mac : '0;
      end
      CMD_TICK:   status = ST_TICKED;
      default:    status = ST_REJECTED;
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cell_cmd),
      .shift_i (shift[g]),
      .prev_i  ((g == 0) ? front : entries[(g == 0) ? 0 : g-1]),
      .entry_o (entries[g]),
      .match_o (match[g]),
      .fresh_o (fresh[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      now_q       <= '0;
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      if (commit && (cmd_q == CMD_TICK)) begin
        now_q <= now_q + STAMP_W'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= cmd_e'(s_axis_tuser);
      ip_q       <= s_axis_tdata[31:0];
      mac_q      <= s_axis_tdata[79:32];
      frame_ok_q <= frame_ok;
    end
    if (commit) begin
      out_status_q <= status;
      out_mac_q    <= mac_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mac_q;
  assign m_axis_tuser  = out_status_q;

  `ASSERT_IMP(a_single_match, clk_i, rst_ni, state_q == FSM_BUSY, $onehot0(match),
              "more than one cell holds the queried IP")
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_fire, state_q == FSM_BUSY,
              "accepted beat did not enter the busy state")
  `ASSERT_NXT(a_tick_advance, clk_i, rst_ni, commit && (cmd_q == CMD_TICK),
              now_q == $past(now_q) + STAMP_W'(1), "tick did not advance the seconds counter")
  `ASSERT_IMP(a_out_source, clk_i, rst_ni, $rose(out_valid_q), $past(commit),
              "result beat appeared without a commit")

endmodule

// ===== hdl/arpc_cell.sv =====
// ----------------------------------------------------------------------------
// arpc_cell
// One position of the recency chain: holds a binding, matches the queried IP
// and checks the binding's age, and takes its neighbor's binding on shift.
// ----------------------------------------------------------------------------
module arpc_cell
  import arpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      shift_i,
  input  entry_t    prev_i,
  output entry_t    entry_o,
  output logic      match_o,
  output logic      fresh_o
);

  logic               valid_q;
  logic [IP_W-1:0]    ip_q;
  logic [MAC_W-1:0]   mac_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               match_q, match_d;
  logic               fresh_q, fresh_d;
  logic [STAMP_W-1:0] age;

  assign age     = cmd_i.now - stamp_q;
  assign match_d = valid_q && (ip_q == cmd_i.ip);
  assign fresh_d = age <= {{(STAMP_W-HALF_W){1'b0}}, cmd_i.timeout};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      fresh_q <= 1'b0;
    end else begin
      if (shift_i) begin
        valid_q <= prev_i.valid;
      end
      if (cmd_i.capture) begin
        match_q <= match_d;
        fresh_q <= fresh_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ip_q    <= prev_i.ip;
      mac_q   <= prev_i.mac;
      stamp_q <= prev_i.stamp;
    end
  end

  assign entry_o = '{valid: valid_q, ip: ip_q, mac: mac_q, stamp: stamp_q};
  assign match_o = match_q;
  assign fresh_o = fresh_q;

endmodule
